[rtl/bpra_pkg.sv]
// Package with the shared types and constants of the bitmap page run allocator.
`default_nettype none

package bpra_pkg;

    localparam int CNT_W      = 13;
    localparam int IDX_W      = 12;
    localparam int POS_W      = 14;
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    localparam logic [CNT_W-1:0] PAGES_RESET = 13'd4096;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } op_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INIT,
        ST_SCAN,
        ST_RANGE_START,
        ST_RANGE,
        ST_FINISH
    } state_e;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [CNT_W-1:0] page_count;
        logic [IDX_W-1:0] first_page;
    } in_item_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] run_start;
        logic [CNT_W-1:0] free_total;
        logic [CNT_W-1:0] used_total;
    } out_item_t;

    typedef struct packed {
        logic load_op;
        logic init_clear;
        logic scan_start;
        logic scan_step;
        logic range_start;
        logic range_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       total_zero;
        logic       scan_hit;
        logic       scan_last;
        logic       range_empty;
        logic       range_last;
    } stat_t;

endpackage

`default_nettype wire

[rtl/bpra_dp.sv]
// Datapath of the allocator: usage map memory, word scanner, run marker and counters.
`default_nettype none

module bpra_dp #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bpra_pkg::in_item_t           in_data,
    input  wire logic                         cfg_we,
    input  wire logic [bpra_pkg::CNT_W-1:0]   cfg_data,
    input  wire bpra_pkg::cmd_t               cmd,
    output bpra_pkg::stat_t                   stat,
    output bpra_pkg::out_item_t               out_data
);

    localparam int WB        = bpra_pkg::WORD_BITS;
    localparam int WS        = bpra_pkg::WORD_SHIFT;
    localparam int PW        = bpra_pkg::POS_W;
    localparam int CW        = bpra_pkg::CNT_W;
    localparam int IW        = bpra_pkg::IDX_W;
    localparam int NUM_WORDS = (MAX_PAGES + WB - 1) / WB;
    localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CAP       = (MAX_PAGES > (1 << CW) - 1) ? (1 << CW) - 1 : MAX_PAGES;
    localparam int PAGE_BITS = PAGE_BYTES * 8;
    localparam logic [WIDX-1:0] LAST_W = WIDX'(NUM_WORDS - 1);
    localparam logic [WB-1:0]   ONES   = {WB{1'b1}};

    function automatic logic [6:0] trail_ones(input logic [WB-1:0] w);
        logic [6:0] n;
        n = 7'(WB);
        for (int i = WB - 1; i >= 0; i--) begin
            if (!w[i]) n = 7'(i);
        end
        return n;
    endfunction

    function automatic logic [6:0] lead_ones(input logic [WB-1:0] w);
        logic [6:0] n;
        n = 7'(WB);
        for (int i = 0; i < WB; i++) begin
            if (!w[i]) n = 7'(WB - 1 - i);
        end
        return n;
    endfunction

    function automatic logic [WS-1:0] low_set(input logic [WB-1:0] w);
        logic [WS-1:0] n;
        n = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (w[i]) n = WS'(i);
        end
        return n;
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                              input logic [CW-1:0] cap);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, cap}) ? cap : s[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    logic [CW-1:0]   pages_reg;
    logic [CW-1:0]   free_reg;
    logic [CW-1:0]   used_reg;
    logic [CW-1:0]   free_next;
    logic [CW-1:0]   used_next;
    logic [CW-1:0]   tot;
    logic [1:0]      op_reg;
    logic [CW-1:0]   count_reg;
    logic [IW-1:0]   first_reg;
    logic            found_reg;
    logic [PW-1:0]   found_start_reg;
    logic [CW-1:0]   run_len_reg;
    logic [PW-1:0]   run_start_reg;
    logic [WIDX-1:0] cur_w_reg;
    logic [WIDX-1:0] nxt_w;
    logic [WIDX-1:0] rd_addr;
    logic [WIDX-1:0] lo_w_reg;
    logic [WIDX-1:0] hi_w_reg;
    logic [WS-1:0]   lo_off_reg;
    logic [WS-1:0]   hi_off_reg;
    logic            set_reg;
    logic [WB-1:0]   map_mem [NUM_WORDS];
    logic [WB-1:0]   rd_word_reg;
    logic [NUM_WORDS-1:0] row_valid_reg;
    logic            rvalid_reg;
    logic            rd_en;
    logic            wr_en;
    logic [WB-1:0]   rword;
    logic [WB-1:0]   v;
    logic [WB-1:0]   limit;
    logic [WB-1:0]   acc;
    logic [WB-1:0]   wmask;
    logic [WB-1:0]   wdata;
    logic [WB-1:0]   g [7];
    logic [6:0]      l0;
    logic [6:0]      lt;
    logic [6:0]      c7;
    logic            short_count;
    logic [PW-1:0]   base;
    logic [PW-1:0]   sum;
    logic [PW-1:0]   pre_start;
    logic [PW-1:0]   hit_start;
    logic [PW-1:0]   fresh_start;
    logic            pre_hit;
    logic            scan_hit;
    logic [2:0]      map_pages;
    logic [PW-1:0]   rlo;
    logic [PW-1:0]   rhi;
    logic [PW-1:0]   rhi_m1;
    logic [PW-1:0]   fend;
    logic            range_empty;
    logic            res_ok;
    logic [IW-1:0]   res_start;
    bpra_pkg::out_item_t out_reg;

    assign tot = (pages_reg > CW'(CAP)) ? CW'(CAP) : pages_reg;

    always_comb
    begin
        map_pages = '0;
        for (int k = 0; k < 4; k++) begin
            if ({19'b0, tot} > 32'(k * PAGE_BITS)) map_pages = map_pages + 3'd1;
        end
    end

    // Usage map memory with one valid bit per word; a word that is not valid reads as free.
    assign nxt_w = (cur_w_reg == LAST_W) ? cur_w_reg : cur_w_reg + 1'b1;
    assign rd_en = cmd.scan_start | cmd.scan_step | cmd.range_start | cmd.range_step;
    assign wr_en = cmd.range_step;

    always_comb
    begin
        if (cmd.scan_start) rd_addr = '0;
        else if (cmd.range_start) rd_addr = WIDX'(rlo >> WS);
        else rd_addr = nxt_w;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) map_mem[cur_w_reg] <= wdata;
        if (rd_en) rd_word_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end else begin
            if (cmd.init_clear) row_valid_reg <= '0;
            else if (wr_en) row_valid_reg[cur_w_reg] <= 1'b1;
            if (rd_en) rvalid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rword = rvalid_reg ? rd_word_reg : '0;

    // Word scanner: a run carried in from lower words, then windows inside the word.
    assign base  = PW'(cur_w_reg) << WS;
    assign limit = (PW'(tot) >= base + PW'(WB)) ? ONES : ~(ONES << tot[WS-1:0]);
    assign v     = ~rword & limit;
    assign l0    = trail_ones(v);
    assign lt    = lead_ones(v);
    assign c7    = count_reg[6:0];
    assign short_count = count_reg <= CW'(WB);

    always_comb
    begin
        g[0] = v;
        for (int k = 1; k < 7; k++) begin
            g[k] = g[k-1] & (g[k-1] >> (1 << (k - 1)));
        end
        acc = ONES;
        for (int k = 0; k < 7; k++) begin
            if (c7[k]) acc = acc & (g[k] >> (c7 & ~7'((1 << (k + 1)) - 1)));
        end
    end

    assign sum         = PW'(run_len_reg) + PW'(l0);
    assign pre_hit     = sum >= PW'(count_reg);
    assign scan_hit    = pre_hit || (short_count && (acc != '0));
    assign pre_start   = (run_len_reg == '0) ? base : run_start_reg;
    assign hit_start   = pre_hit ? pre_start : base + PW'(low_set(acc));
    assign fresh_start = (l0 == 7'(WB)) ? pre_start : base + PW'(WB) - PW'(lt);

    // Page range that the marker sets or clears for the current operation.
    always_comb
    begin
        fend = PW'(first_reg) + PW'(count_reg);
        case (op_reg)
            bpra_pkg::OP_INIT: begin
                rlo = '0;
                rhi = PW'(map_pages);
            end
            bpra_pkg::OP_ALLOC: begin
                rlo = found_start_reg;
                rhi = found_start_reg + PW'(count_reg);
            end
            default: begin
                rlo = PW'(first_reg);
                rhi = (fend > PW'(tot)) ? PW'(tot) : fend;
            end
        endcase
    end

    assign range_empty = rlo >= rhi;
    assign rhi_m1      = rhi - 1'b1;

    assign wmask = ((cur_w_reg == lo_w_reg) ? (ONES << lo_off_reg) : ONES)
                 & ((cur_w_reg == hi_w_reg) ? (ONES >> (WS'(WB - 1) - hi_off_reg)) : ONES);
    assign wdata = set_reg ? (rword | wmask) : (rword & ~wmask);

    always_comb
    begin
        free_next = free_reg;
        used_next = used_reg;
        res_ok    = 1'b0;
        res_start = '0;
        case (op_reg)
            bpra_pkg::OP_INIT: begin
                used_next = CW'(map_pages);
                free_next = tot - CW'(map_pages);
                res_ok    = 1'b1;
            end
            bpra_pkg::OP_ALLOC: begin
                if (found_reg) begin
                    used_next = sat_add(used_reg, count_reg, tot);
                    free_next = sat_sub(free_reg, count_reg);
                    res_ok    = 1'b1;
                    res_start = found_start_reg[IW-1:0];
                end
            end
            bpra_pkg::OP_FREE: begin
                used_next = sat_sub(used_reg, count_reg);
                free_next = sat_add(free_reg, count_reg, tot);
                res_ok    = 1'b1;
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pages_reg <= bpra_pkg::PAGES_RESET;
            free_reg  <= '0;
            used_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cfg_we) pages_reg <= cfg_data;
            if (cmd.commit) begin
                free_reg <= free_next;
                used_reg <= used_next;
            end
            if (cmd.load_op) found_reg <= 1'b0;
            else if (cmd.scan_step && scan_hit) found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op) begin
            op_reg    <= in_data.opcode;
            count_reg <= in_data.page_count;
            first_reg <= in_data.first_page;
        end
        if (cmd.scan_start) begin
            run_len_reg   <= '0;
            run_start_reg <= '0;
        end else if (cmd.scan_step) begin
            run_len_reg   <= (l0 == 7'(WB)) ? CW'(sum) : CW'(lt);
            run_start_reg <= fresh_start;
        end
        if (cmd.scan_step && scan_hit) found_start_reg <= hit_start;
        if (cmd.scan_start) cur_w_reg <= '0;
        else if (cmd.range_start) cur_w_reg <= WIDX'(rlo >> WS);
        else if (cmd.scan_step || cmd.range_step) cur_w_reg <= nxt_w;
        if (cmd.range_start) begin
            lo_w_reg   <= WIDX'(rlo >> WS);
            hi_w_reg   <= WIDX'(rhi_m1 >> WS);
            lo_off_reg <= rlo[WS-1:0];
            hi_off_reg <= rhi_m1[WS-1:0];
            set_reg    <= op_reg != bpra_pkg::OP_FREE;
        end
        if (cmd.commit) begin
            out_reg.ok         <= res_ok;
            out_reg.run_start  <= res_start;
            out_reg.free_total <= free_next;
            out_reg.used_total <= used_next;
        end
    end

    assign out_data         = out_reg;
    assign stat.op          = op_reg;
    assign stat.count_zero  = count_reg == '0;
    assign stat.total_zero  = tot == '0;
    assign stat.scan_hit    = scan_hit;
    assign stat.scan_last   = PW'(tot) <= base + PW'(WB);
    assign stat.range_empty = range_empty;
    assign stat.range_last  = cur_w_reg == hi_w_reg;

    a_hit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && scan_hit) |=>
        (found_reg && (({1'b0, found_start_reg} + (PW + 1)'(count_reg)) <= (PW + 1)'(tot))))
        else $error("found run does not fit below the page total");

    a_range_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.range_step |-> (cur_w_reg >= lo_w_reg && cur_w_reg <= hi_w_reg))
        else $error("marker word outside the run");

    a_mask_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.range_step |-> (wmask != '0))
        else $error("marker writes a word with an empty mask");

endmodule

`default_nettype wire

[rtl/bpra_ctrl.sv]
// Controller state machine that sequences init, scan, marking and result delivery.
`default_nettype none

module bpra_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire bpra_pkg::stat_t stat,
    output bpra_pkg::cmd_t       cmd
);

    bpra_pkg::state_e state_reg;
    bpra_pkg::state_e state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= bpra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            bpra_pkg::ST_IDLE: begin
                if (in_valid) begin
                    cmd.load_op = 1'b1;
                    state_next  = bpra_pkg::ST_DISPATCH;
                end
            end
            bpra_pkg::ST_DISPATCH: begin
                case (stat.op)
                    bpra_pkg::OP_INIT: begin
                        state_next = bpra_pkg::ST_INIT;
                    end
                    bpra_pkg::OP_ALLOC: begin
                        if (stat.count_zero || stat.total_zero) begin
                            state_next = bpra_pkg::ST_FINISH;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = bpra_pkg::ST_SCAN;
                        end
                    end
                    bpra_pkg::OP_FREE: begin
                        state_next = bpra_pkg::ST_RANGE_START;
                    end
                    default: begin
                        state_next = bpra_pkg::ST_FINISH;
                    end
                endcase
            end
            bpra_pkg::ST_INIT: begin
                cmd.init_clear = 1'b1;
                state_next     = bpra_pkg::ST_RANGE_START;
            end
            bpra_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit) state_next = bpra_pkg::ST_RANGE_START;
                else if (stat.scan_last) state_next = bpra_pkg::ST_FINISH;
            end
            bpra_pkg::ST_RANGE_START: begin
                if (stat.range_empty) begin
                    state_next = bpra_pkg::ST_FINISH;
                end else begin
                    cmd.range_start = 1'b1;
                    state_next      = bpra_pkg::ST_RANGE;
                end
            end
            bpra_pkg::ST_RANGE: begin
                cmd.range_step = 1'b1;
                if (stat.range_last) state_next = bpra_pkg::ST_FINISH;
            end
            bpra_pkg::ST_FINISH: begin
                if (!out_valid_reg || !out_stall) begin
                    cmd.commit = 1'b1;
                    state_next = bpra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpra_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall) out_valid_next = 1'b0;
    end

    assign in_stall  = state_reg != bpra_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while a transaction is pending");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("output valid raised without a commit");

endmodule

`default_nettype wire

[rtl/bitmap_page_run_allocator.sv]
// Top level of the bitmap first-fit page run allocator.
//
//   channel   direction   handshake            payload
//   in        input       in_valid / in_stall  bpra_pkg::in_item_t
//   out       output      out_valid / out_stall bpra_pkg::out_item_t
//   cfg       input       cfg_valid / cfg_ready cfg_data (page total)
//
// The map is held as 64-page words; an allocation scans one word per cycle from page 0
// and then marks one word per cycle.
// Reset clears the map through per-word valid bits at once, so no clearing pass is needed.
// One transaction is worked on at a time; a new one is taken while a result still waits,
// and a stalled result holds the block in its final state.
`default_nettype none

module bitmap_page_run_allocator #(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire bpra_pkg::in_item_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output bpra_pkg::out_item_t               out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bpra_pkg::CNT_W-1:0]   cfg_data
);

    bpra_pkg::cmd_t  cmd;
    bpra_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bpra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpra_dp #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
